>>> rtl/cqtc_pkg.sv
// ----------------------------------------------------------------------------
// cqtc_pkg
// Shared types and constants for the circular queue with type count unit.
// ----------------------------------------------------------------------------
package cqtc_pkg;

   // default queue depth
   localparam int DEPTH_DEFAULT = 8;

   // opcodes
   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_DEQUEUE = 3'd1;
   localparam logic [2:0] OP_CLEAR   = 3'd2;
   localparam logic [2:0] OP_PEEK    = 3'd3;
   localparam logic [2:0] OP_COUNT   = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // request beat
   typedef struct packed {
      logic [2:0]         opcode;
      logic [7:0]         item_type;
      logic signed [31:0] process_number;
   } req_type;

   // response beat
   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         out_type;
      logic signed [31:0] out_process;
      logic [3:0]         match_count;
      logic               last_result;
   } rsp_type;

   // one stored queue entry
   typedef struct packed {
      logic [7:0]         item_type;
      logic signed [31:0] process_number;
   } entry_type;

   // handshake between controller and the beat registers
   typedef struct packed {
      logic consume;
      logic emit;
   } ctl_type;

   // controller states
   typedef enum logic [1:0] {
      CQ_IDLE,
      CQ_READ,
      CQ_WALK,
      CQ_FINAL
   } state_type;

endpackage

>>> rtl/cqtc_mem.sv
// ----------------------------------------------------------------------------
// cqtc_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cqtc_mem
   import cqtc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cqtc_ctrl.sv
// ----------------------------------------------------------------------------
// cqtc_ctrl
// Queue controller: head/tail/occupancy pointers, opcode sequencing and the
// head-to-tail walk for count by type.
// ----------------------------------------------------------------------------
module cqtc_ctrl
   import cqtc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     hold_valid,
   input  req_type                  hold_data,
   input  logic                     out_free,
   output ctl_type                  ctl,
   output rsp_type                  emit_data,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output entry_type                wr_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  entry_type                rd_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] walk_ff, walk_in;
   logic [OCC_W-1:0] left_ff, left_in;
   logic [OCC_W-1:0] cnt_ff, cnt_in;

   logic             is_empty;
   logic             is_full;
   logic             is_match;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      next_slot = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff == OCC_W'(DEPTH));
   assign is_match = (rd_data.item_type == hold_data.item_type);

   // state and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CQ_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      left_ff <= left_in;
      cnt_ff  <= cnt_in;
   end

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      walk_in     = walk_ff;
      left_in     = left_ff;
      cnt_in      = cnt_ff;
      ctl         = '0;
      emit_data   = '0;
      wr_en       = 1'b0;
      wr_addr     = tail_ff;
      wr_data.item_type      = hold_data.item_type;
      wr_data.process_number = hold_data.process_number;
      rd_en       = 1'b0;
      rd_addr     = head_ff;

      case (state_ff)
         CQ_IDLE: begin
            if (hold_valid && out_free) begin
               emit_data.last_result = 1'b1;
               case (hold_data.opcode)
                  OP_ENQUEUE: begin
                     ctl.consume = 1'b1;
                     ctl.emit    = 1'b1;
                     if (is_full) begin
                        emit_data.status = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = next_slot(tail_ff);
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  OP_DEQUEUE, OP_PEEK: begin
                     if (is_empty) begin
                        ctl.consume      = 1'b1;
                        ctl.emit         = 1'b1;
                        emit_data.status = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = CQ_READ;
                     end
                  end
                  OP_CLEAR: begin
                     ctl.consume = 1'b1;
                     ctl.emit    = 1'b1;
                     head_in     = '0;
                     tail_in     = '0;
                     occ_in      = '0;
                  end
                  OP_COUNT: begin
                     if (is_empty) begin
                        ctl.consume      = 1'b1;
                        ctl.emit         = 1'b1;
                        emit_data.status = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        walk_in  = next_slot(head_ff);
                        left_in  = occ_ff;
                        cnt_in   = '0;
                        state_in = CQ_WALK;
                     end
                  end
                  default: begin
                     ctl.consume = 1'b1;
                     ctl.emit    = 1'b1;
                  end
               endcase
            end
         end

         // head entry is in the read register
         CQ_READ: begin
            if (out_free) begin
               ctl.consume           = 1'b1;
               ctl.emit              = 1'b1;
               emit_data.out_type    = rd_data.item_type;
               emit_data.out_process = rd_data.process_number;
               emit_data.last_result = 1'b1;
               if (hold_data.opcode == OP_DEQUEUE) begin
                  head_in = next_slot(head_ff);
                  occ_in  = occ_ff - 1'b1;
               end
               state_in = CQ_IDLE;
            end
         end

         // one entry per cycle; stall only when a match cannot be sent
         CQ_WALK: begin
            if (!is_match || out_free) begin
               if (is_match) begin
                  ctl.emit              = 1'b1;
                  emit_data.out_type    = hold_data.item_type;
                  emit_data.out_process = rd_data.process_number;
                  cnt_in                = cnt_ff + 1'b1;
               end
               if (left_ff == OCC_W'(1)) begin
                  state_in = CQ_FINAL;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = walk_ff;
                  walk_in = next_slot(walk_ff);
                  left_in = left_ff - 1'b1;
               end
            end
         end

         // closing beat with the match count
         CQ_FINAL: begin
            if (out_free) begin
               ctl.consume           = 1'b1;
               ctl.emit              = 1'b1;
               emit_data.out_type    = hold_data.item_type;
               emit_data.match_count = 4'(cnt_ff);
               emit_data.last_result = 1'b1;
               state_in              = CQ_IDLE;
            end
         end

         default: begin
            state_in = CQ_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/circular_queue_with_type_count_unit.sv
// ----------------------------------------------------------------------------
// circular_queue_with_type_count_unit
// Circular FIFO of type/process entries with enqueue, dequeue, clear, peek
// and count-by-type. Enqueue/clear respond from the idle state, dequeue/peek
// after the registered head read; count reads one entry per cycle from the
// entry store while no match waits on a busy response register. One request
// in flight; a new request beat is held while the previous response waits.
// Synchronous reset empties the queue; stored entries are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_type_count_unit
   import cqtc_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);

   logic             hold_valid_ff, hold_valid_in;
   req_type          hold_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff;
   logic             out_free;
   ctl_type          ctl;
   rsp_type          emit_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   assign req_ready = !hold_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   // request holding register
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
      end else if (ctl.consume) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_ff <= req_data;
      end
   end

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctl.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         out_ff <= emit_data;
      end
   end

   // controller
   cqtc_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid_ff),
      .hold_data  (hold_ff),
      .out_free   (out_free),
      .ctl        (ctl),
      .emit_data  (emit_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // entry store
   cqtc_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

>>> verif/tb_circular_queue_with_type_count_unit.sv
// ----------------------------------------------------------------------------
// tb_circular_queue_with_type_count_unit
// Self-checking testbench for the circular queue with type count unit. A
// directed sequence covers the empty, full, wrap and unused opcode cases.
// Random operation mixes follow, with a fill bias that changes per phase.
// A shadow queue predicts every response beat. Beats are compared field by
// field in order, while both handshakes idle in random bursts and one long
// receiver hold-off backs the unit up.
// ----------------------------------------------------------------------------
module tb_circular_queue_with_type_count_unit;
   import cqtc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RANDOM_OPS   = 355;
   localparam int CALM_TAIL    = 40;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the queue contents
   logic [7:0]  shadow_type [DEPTH];
   logic [31:0] shadow_proc [DEPTH];
   int unsigned shadow_head = 0;
   int unsigned shadow_tail = 0;
   int unsigned shadow_fill = 0;

   req_type     op_backlog[$];
   rsp_type     outcome_fifo[$];
   int unsigned items_accepted = 0;
   int unsigned beats_checked  = 0;
   int unsigned error_count    = 0;
   int unsigned walks_done     = 0;
   int unsigned full_rejects   = 0;
   int unsigned widest_match   = 0;
   int unsigned cycle_count    = 0;
   int unsigned gap_left       = 0;
   int unsigned stall_left     = 0;
   int unsigned hold_left      = 0;
   logic        hold_done      = 1'b0;
   logic        calm;
   logic        idle_phase;

   circular_queue_with_type_count_unit #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   // no idling near the end, and idling only in alternating stretches
   assign calm       = (op_backlog.size() < CALM_TAIL);
   assign idle_phase = ((items_accepted / 30) % 2) == 0;

   task automatic flag_error(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic req_type make_req(logic [2:0] op, logic [7:0] typ, logic [31:0] proc);
      req_type r;
      r.opcode         = op;
      r.item_type      = typ;
      r.process_number = proc;
      return r;
   endfunction

   // apply one accepted beat to the shadow queue, queue its response beats
   task automatic apply_queue_op(req_type r);
      rsp_type     b;
      rsp_type     hit;
      int unsigned idx;
      int unsigned hits;
      b             = '0;
      b.status      = STATUS_OK;
      b.last_result = 1'b1;
      case (r.opcode)
         OP_ENQUEUE: begin
            if (shadow_fill >= DEPTH) begin
               b.status = STATUS_FULL;
               full_rejects++;
            end else begin
               shadow_type[shadow_tail] = r.item_type;
               shadow_proc[shadow_tail] = r.process_number;
               shadow_tail = (shadow_tail + 1) % DEPTH;
               shadow_fill++;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (shadow_fill == 0) begin
               b.status = STATUS_EMPTY;
            end else begin
               b.out_type    = shadow_type[shadow_head];
               b.out_process = shadow_proc[shadow_head];
               if (r.opcode == OP_DEQUEUE) begin
                  shadow_head = (shadow_head + 1) % DEPTH;
                  shadow_fill--;
               end
            end
         end
         OP_CLEAR: begin
            shadow_head = 0;
            shadow_tail = 0;
            shadow_fill = 0;
         end
         OP_COUNT: begin
            if (shadow_fill == 0) begin
               b.status = STATUS_EMPTY;
            end else begin
               idx  = shadow_head;
               hits = 0;
               for (int n = 0; n < shadow_fill; n++) begin
                  if (shadow_type[idx] == r.item_type) begin
                     hit             = '0;
                     hit.status      = STATUS_OK;
                     hit.out_type    = r.item_type;
                     hit.out_process = shadow_proc[idx];
                     outcome_fifo.push_back(hit);
                     hits++;
                  end
                  idx = (idx + 1) % DEPTH;
               end
               b.out_type    = r.item_type;
               b.match_count = hits[3:0];
               walks_done++;
               if (hits > widest_match) widest_match = hits;
            end
         end
         default: begin
            // unused opcodes give a plain ok beat
         end
      endcase
      outcome_fifo.push_back(b);
   endtask

   task automatic check_beat(rsp_type got, rsp_type want);
      if (got.status !== want.status)
         flag_error($sformatf("beat %0d status %0d, want %0d",
                              beats_checked, got.status, want.status));
      if (got.out_type !== want.out_type)
         flag_error($sformatf("beat %0d out_type %h, want %h",
                              beats_checked, got.out_type, want.out_type));
      if (got.out_process !== want.out_process)
         flag_error($sformatf("beat %0d out_process %h, want %h",
                              beats_checked, got.out_process, want.out_process));
      if (got.match_count !== want.match_count)
         flag_error($sformatf("beat %0d match_count %0d, want %0d",
                              beats_checked, got.match_count, want.match_count));
      if (got.last_result !== want.last_result)
         flag_error($sformatf("beat %0d last_result %b, want %b",
                              beats_checked, got.last_result, want.last_result));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_queue_op(req_data);
            items_accepted <= items_accepted + 1;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (op_backlog.size() != 0 && !calm && idle_phase
                         && $urandom_range(0, 4) == 0) begin
               gap_left  <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (op_backlog.size() != 0) begin
               req_data  <= op_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, once, so the unit backs up onto its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response ready with random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && idle_phase && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_fifo.size() == 0)
            flag_error($sformatf("unexpected beat %h", rsp_data));
         else
            check_beat(rsp_data, outcome_fifo.pop_front());
         beats_checked++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [2:0]  op;
      logic [7:0]  typ;
      logic [7:0]  focus_type;
      int unsigned enq_bias;
      int unsigned roll;

      // directed: empty cases and unused opcodes
      op_backlog.push_back(make_req(OP_COUNT, 8'h00, 32'h0));
      op_backlog.push_back(make_req(OP_DEQUEUE, 8'hff, 32'hffff_ffff));
      op_backlog.push_back(make_req(OP_PEEK, 8'h00, 32'h0));
      op_backlog.push_back(make_req(3'd5, 8'hff, 32'hffff_ffff));
      op_backlog.push_back(make_req(3'd6, 8'h00, 32'h0));
      op_backlog.push_back(make_req(3'd7, 8'h3c, 32'h1234_5678));
      // fill to full with extreme values, then one more
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'h7fff_ffff));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'h00, 32'h8000_0000));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'hffff_ffff));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'h0000_0000));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'h0000_0001));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'h5555_5555));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'haaaa_aaaa));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'h0000_007b));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'h5a, 32'h0bad_cafe));
      // count walks on a full queue: many, one and no matches
      op_backlog.push_back(make_req(OP_COUNT, 8'hff, 32'h0));
      op_backlog.push_back(make_req(OP_COUNT, 8'h00, 32'h0));
      op_backlog.push_back(make_req(OP_COUNT, 8'h77, 32'h0));
      // head reads, then wrap the tail
      op_backlog.push_back(make_req(OP_PEEK, 8'h00, 32'h0));
      op_backlog.push_back(make_req(OP_DEQUEUE, 8'h00, 32'h0));
      op_backlog.push_back(make_req(OP_DEQUEUE, 8'h00, 32'h0));
      op_backlog.push_back(make_req(OP_ENQUEUE, 8'hff, 32'hdead_beef));
      op_backlog.push_back(make_req(OP_COUNT, 8'hff, 32'h0));
      op_backlog.push_back(make_req(OP_CLEAR, 8'h00, 32'h0));
      op_backlog.push_back(make_req(OP_COUNT, 8'hff, 32'h0));

      // random: phases with their own fill bias and a favored type
      enq_bias   = 50;
      focus_type = 8'h00;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) begin
            enq_bias   = $urandom_range(30, 70);
            focus_type = 8'($urandom);
         end
         if ($urandom_range(0, 99) < enq_bias) begin
            op = OP_ENQUEUE;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 35)      op = OP_DEQUEUE;
            else if (roll < 55) op = OP_PEEK;
            else if (roll < 85) op = OP_COUNT;
            else if (roll < 93) op = OP_CLEAR;
            else                op = 3'($urandom_range(5, 7));
         end
         roll = $urandom_range(0, 3);
         if (roll < 2)       typ = focus_type;
         else if (roll == 2) typ = 8'($urandom_range(0, 3));
         else                typ = 8'($urandom);
         op_backlog.push_back(make_req(op, typ, $urandom));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for every beat to go in and every response to come back
      while (op_backlog.size() != 0 || req_valid || outcome_fifo.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      // anything still predicted never came back
      if (outcome_fifo.size() != 0)
         flag_error($sformatf("%0d response beats never arrived", outcome_fifo.size()));

      $display("ran %0d requests, checked %0d response beats, %0d errors",
               items_accepted, beats_checked, error_count);
      $display("count walks %0d (up to %0d matches), full rejects %0d",
               walks_done, widest_match, full_rejects);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
